>>> rtl/gga_position_extract_defines.svh
// Assertion macros for the checker file of this block.
`ifndef GGA_POSITION_EXTRACT_DEFINES_SVH
`define GGA_POSITION_EXTRACT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gpe check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define GPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gpe check failed: next-cycle rule");

`endif

>>> rtl/gpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpe_pkg;

	// Field sizes of the captured position.
	localparam int LAT_CHARS = 10;
	localparam int LON_CHARS = 11;
	localparam int POS_DEPTH = LAT_CHARS + LON_CHARS;
	localparam int ADDR_W = $clog2(POS_DEPTH);

	// Command layout: prefix, hex of position and comma, then CR LF.
	localparam int PREFIX_LEN = 15;
	localparam int HEADER_LEN = 6;
	localparam int CMD_LEN = PREFIX_LEN + 2 * (POS_DEPTH + 1) + 2;
	localparam int CNT_W = $clog2(CMD_LEN);

	// Result status codes.
	localparam logic [1:0] STAT_CMD = 2'd0;
	localparam logic [1:0] STAT_LAT = 2'd1;
	localparam logic [1:0] STAT_LON = 2'd2;

	// Job codes passed from the parser to the emitter.
	localparam logic [1:0] JOB_ERR_LAT = 2'd0;
	localparam logic [1:0] JOB_ERR_LON = 2'd1;
	localparam logic [1:0] JOB_CMD = 2'd2;

	localparam logic [7:0] CHAR_COMMA = 8'h2c;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;

	typedef struct packed {
		logic [7:0] data_byte;
		logic sentence_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic last;
	} out_item_t;

	// One position character write from the parser into the emitter's store.
	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		logic [7:0] data;
	} pos_wr_t;

	// Queue status seen by the parser.
	typedef struct packed {
		logic full;
		logic has_cmd;
	} q_stat_t;

	// Lowercase hex digit of a nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'h0, nib};
		end else begin
			r = 8'h57 + {4'h0, nib};
		end
		return r;
	endfunction

	// Characters of the sentence header "$GNGGA".
	function automatic logic [7:0] header_char(input logic [2:0] idx);
		logic [7:0] r;
		unique case (idx)
			3'd0: r = 8'h24;
			3'd1: r = 8'h47;
			3'd2: r = 8'h4e;
			3'd3: r = 8'h47;
			3'd4: r = 8'h47;
			3'd5: r = 8'h41;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Characters of the command prefix "AT+NMGS=24,0016".
	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] r;
		unique case (idx)
			4'd0: r = 8'h41;
			4'd1: r = 8'h54;
			4'd2: r = 8'h2b;
			4'd3: r = 8'h4e;
			4'd4: r = 8'h4d;
			4'd5: r = 8'h47;
			4'd6: r = 8'h53;
			4'd7: r = 8'h3d;
			4'd8: r = 8'h32;
			4'd9: r = 8'h34;
			4'd10: r = 8'h2c;
			4'd11: r = 8'h30;
			4'd12: r = 8'h30;
			4'd13: r = 8'h31;
			4'd14: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/gpe_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Sentence parser: splits the byte stream into fields, checks the header,
// captures the position characters and queues a job for each judged position.
module gpe_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_valid,
	input wire gpe_pkg::in_item_t byte_item,
	output logic byte_stall,
	input wire gpe_pkg::q_stat_t q_stat,
	input wire logic back_busy,
	output logic push,
	output logic [1:0] push_job,
	output gpe_pkg::pos_wr_t pos_wr
);
	import gpe_pkg::*;

	logic [2:0] tok_idx_q, tok_idx_d;
	logic [3:0] tok_len_q, tok_len_d;
	logic in_tok_q, in_tok_d;
	logic hdr_ok_q, hdr_ok_d;
	logic fin_q, fin_d;
	logic accept;

	// Hold input while the queue is full or the position store is in use.
	assign byte_stall = q_stat.full | q_stat.has_cmd | back_busy;
	assign accept = byte_valid & ~byte_stall;

	// Parse step for one accepted byte.
	always_comb begin
		logic [7:0] c;
		logic [3:0] pos;
		logic [4:0] lon_addr;
		c = byte_item.data_byte;
		pos = 4'd0;
		lon_addr = 5'd0;
		tok_idx_d = tok_idx_q;
		tok_len_d = tok_len_q;
		in_tok_d = in_tok_q;
		hdr_ok_d = hdr_ok_q;
		fin_d = fin_q;
		push = 1'b0;
		push_job = JOB_CMD;
		pos_wr = '0;
		if (accept) begin
			if (byte_item.sentence_start) begin
				tok_idx_d = 3'd0;
				tok_len_d = 4'd0;
				in_tok_d = 1'b0;
				hdr_ok_d = 1'b1;
				fin_d = 1'b0;
			end
			if (!fin_d) begin
				if (c == CHAR_COMMA || c == CHAR_NUL) begin
					// A separator closes an open field and judges it.
					if (in_tok_d) begin
						if (tok_idx_d == 3'd0) begin
							if (!hdr_ok_d || tok_len_d < 4'(HEADER_LEN)) begin
								fin_d = 1'b1;
							end
						end else if (tok_idx_d == 3'd2) begin
							if (tok_len_d != 4'(LAT_CHARS)) begin
								push = 1'b1;
								push_job = JOB_ERR_LAT;
								fin_d = 1'b1;
							end
						end else if (tok_idx_d == 3'd4) begin
							push = 1'b1;
							push_job = (tok_len_d != 4'(LON_CHARS)) ? JOB_ERR_LON : JOB_CMD;
							fin_d = 1'b1;
						end
						tok_idx_d = tok_idx_d + 3'd1;
						in_tok_d = 1'b0;
					end
					if (c == CHAR_NUL) begin
						fin_d = 1'b1;
					end
				end else begin
					// A field character: check header, capture position.
					if (!in_tok_d) begin
						in_tok_d = 1'b1;
						tok_len_d = 4'd0;
					end
					pos = tok_len_d;
					if (tok_idx_d == 3'd0 && pos < 4'(HEADER_LEN) &&
							c != header_char(pos[2:0])) begin
						hdr_ok_d = 1'b0;
					end
					if (tok_idx_d == 3'd2 && pos < 4'(LAT_CHARS)) begin
						pos_wr.en = 1'b1;
						pos_wr.addr = ADDR_W'(pos);
						pos_wr.data = c;
					end
					lon_addr = {1'b0, pos} + 5'(LAT_CHARS);
					if (tok_idx_d == 3'd4 && pos < 4'(LON_CHARS)) begin
						pos_wr.en = 1'b1;
						pos_wr.addr = ADDR_W'(lon_addr);
						pos_wr.data = c;
					end
					if (tok_len_d != 4'd15) begin
						tok_len_d = tok_len_d + 4'd1;
					end
				end
			end
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_idx_q <= 3'd0;
			tok_len_q <= 4'd0;
			in_tok_q <= 1'b0;
			hdr_ok_q <= 1'b1;
			fin_q <= 1'b1;
		end else begin
			tok_idx_q <= tok_idx_d;
			tok_len_q <= tok_len_d;
			in_tok_q <= in_tok_d;
			hdr_ok_q <= hdr_ok_d;
			fin_q <= fin_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gpe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry job queue; entry 0 is the head, entries shift on a pop.
module gpe_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [1:0] push_job,
	input wire logic pop,
	output logic head_valid,
	output logic [1:0] head_job,
	output gpe_pkg::q_stat_t q_stat
);
	import gpe_pkg::*;

	logic v0_q, v1_q;
	logic [1:0] e0_q, e1_q;
	logic nv0, nv1;
	logic [1:0] ne0, ne1;

	assign head_valid = v0_q;
	assign head_job = e0_q;
	assign q_stat.full = v1_q;
	assign q_stat.has_cmd = (v0_q && e0_q == JOB_CMD) || (v1_q && e1_q == JOB_CMD);

	// Shift on pop, then append the pushed job at the first free entry.
	always_comb begin
		if (pop) begin
			nv0 = v1_q;
			ne0 = e1_q;
			nv1 = 1'b0;
			ne1 = e1_q;
		end else begin
			nv0 = v0_q;
			ne0 = e0_q;
			nv1 = v1_q;
			ne1 = e1_q;
		end
		if (push) begin
			if (!nv0) begin
				nv0 = 1'b1;
				ne0 = push_job;
			end else begin
				nv1 = 1'b1;
				ne1 = push_job;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= nv0;
			v1_q <= nv1;
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= ne0;
		e1_q <= ne1;
	end

endmodule

`default_nettype wire

>>> rtl/gpe_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Result emitter: holds the position store and turns each job into
// result items through an output register.
module gpe_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire gpe_pkg::pos_wr_t pos_wr,
	input wire logic head_valid,
	input wire logic [1:0] head_job,
	output logic pop,
	output logic busy,
	output logic cmd_valid,
	output gpe_pkg::out_item_t cmd_item,
	input wire logic cmd_stall
);
	import gpe_pkg::*;

	logic [7:0] pos_q [POS_DEPTH];
	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	out_item_t out_item_q;
	out_item_t nxt_item;
	logic load;
	logic [CNT_W-1:0] k;
	logic [7:0] cmd_byte;

	assign load = ~out_valid_q | ~cmd_stall;
	assign pop = load & ~busy_q & head_valid;
	assign busy = busy_q;
	assign cmd_valid = out_valid_q;
	assign cmd_item = out_item_q;

	// Position store, written by the parser one character at a time.
	always_ff @(posedge clk) begin
		if (pos_wr.en) begin
			pos_q[pos_wr.addr] <= pos_wr.data;
		end
	end

	// Character of the command at position k.
	assign k = busy_q ? cnt_q : '0;
	always_comb begin
		logic [CNT_W-1:0] h;
		logic [CNT_W-1:0] ci;
		logic [CNT_W-1:0] mi;
		logic [7:0] ch;
		h = k - CNT_W'(PREFIX_LEN);
		ci = h >> 1;
		mi = (ci < CNT_W'(LAT_CHARS)) ? ci : ci - CNT_W'(1);
		ch = (ci == CNT_W'(LAT_CHARS)) ? CHAR_COMMA : pos_q[mi[ADDR_W-1:0]];
		if (k < CNT_W'(PREFIX_LEN)) begin
			cmd_byte = prefix_char(k[3:0]);
		end else if (k == CNT_W'(CMD_LEN - 2)) begin
			cmd_byte = CHAR_CR;
		end else if (k == CNT_W'(CMD_LEN - 1)) begin
			cmd_byte = CHAR_LF;
		end else begin
			cmd_byte = hex_char(h[0] ? ch[3:0] : ch[7:4]);
		end
	end

	// Next result item: continue a command or start the head job.
	always_comb begin
		nxt_item.out_byte = cmd_byte;
		nxt_item.status = STAT_CMD;
		nxt_item.last = 1'b0;
		if (busy_q) begin
			nxt_item.last = (cnt_q == CNT_W'(CMD_LEN - 1));
		end else begin
			unique case (head_job)
				JOB_ERR_LAT: begin
					nxt_item.out_byte = 8'h00;
					nxt_item.status = STAT_LAT;
					nxt_item.last = 1'b1;
				end
				JOB_ERR_LON: begin
					nxt_item.out_byte = 8'h00;
					nxt_item.status = STAT_LON;
					nxt_item.last = 1'b1;
				end
				default: begin
					nxt_item.last = 1'b0;
				end
			endcase
		end
	end

	// Emission control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			out_valid_q <= busy_q | head_valid;
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(CMD_LEN - 1)) begin
					busy_q <= 1'b0;
				end
			end else if (head_valid && head_job == JOB_CMD) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(1);
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load && (busy_q || head_valid)) begin
			out_item_q <= nxt_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gga_position_extract.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake              | Item
// byte     | byte_valid, byte_stall | data_byte, sentence_start
// cmd      | cmd_valid, cmd_stall   | out_byte, status, last
//
// One sentence byte is taken per cycle while the job queue has room.
// A good sentence holds the byte input while its command is queued and sent
// (plus output stalls), since the emitter reads the position store then.
// Error results are a single item and only stall input when the queue is full.
// Reset leaves the block idle until a byte marked as sentence start.
// The result register lets the input run while a result waits on cmd_stall.
module gga_position_extract (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_valid,
	input wire gpe_pkg::in_item_t byte_item,
	output logic byte_stall,
	output logic cmd_valid,
	output gpe_pkg::out_item_t cmd_item,
	input wire logic cmd_stall
);
	import gpe_pkg::*;

	q_stat_t q_stat;
	logic back_busy;
	logic push;
	logic [1:0] push_job;
	pos_wr_t pos_wr;
	logic pop;
	logic head_valid;
	logic [1:0] head_job;

	// Parser front.
	gpe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_item(byte_item),
		.byte_stall(byte_stall),
		.q_stat(q_stat),
		.back_busy(back_busy),
		.push(push),
		.push_job(push_job),
		.pos_wr(pos_wr)
	);

	// Job queue between the two halves.
	gpe_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head_valid(head_valid),
		.head_job(head_job),
		.q_stat(q_stat)
	);

	// Result emitter.
	gpe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pos_wr(pos_wr),
		.head_valid(head_valid),
		.head_job(head_job),
		.pop(pop),
		.busy(back_busy),
		.cmd_valid(cmd_valid),
		.cmd_item(cmd_item),
		.cmd_stall(cmd_stall)
	);

endmodule

`default_nettype wire

>>> rtl/gpe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "gga_position_extract_defines.svh"

// Port-level checks on the position extractor.
module gpe_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_stall,
	input wire logic cmd_valid,
	input wire gpe_pkg::out_item_t cmd_item,
	input wire logic cmd_stall
);
	import gpe_pkg::*;

	logic err_item;
	logic cmd_body;
	logic cmd_end;
	logic held;

	assign err_item = cmd_valid && cmd_item.status != STAT_CMD;
	assign cmd_body = cmd_valid && cmd_item.status == STAT_CMD && !cmd_item.last;
	assign cmd_end = cmd_valid && cmd_item.status == STAT_CMD && cmd_item.last;
	assign held = cmd_valid && cmd_stall;

	// A stalled result stays in place.
	`GPE_ASSERT_NEXT(a_hold, clk, arst_n, held, cmd_valid && $stable(cmd_item))
	// An error result is a single zero item.
	`GPE_ASSERT_SAME(a_err, clk, arst_n, err_item, cmd_item.last && cmd_item.out_byte == 8'h00)
	// A command always ends on line feed.
	`GPE_ASSERT_SAME(a_end, clk, arst_n, cmd_end, cmd_item.out_byte == CHAR_LF)
	// Input is held while a command is still being streamed out.
	`GPE_ASSERT_SAME(a_busy, clk, arst_n, cmd_body, byte_stall)

endmodule

bind gga_position_extract gpe_checker u_gpe_checker (.*);

`default_nettype wire

>>> tb/tb_gga_position_extract.sv
`timescale 1ns / 1ps

module tb_gga_position_extract;
	import gpe_pkg::*;

	localparam int RUN_LIMIT = 300000;
	localparam int RANDOM_BYTES = 80;
	localparam int PRINT_CAP = 200;
	localparam int SETTLE_CYCLES = 64;
	localparam int BACKPRESSURE_CYCLES = 400;

	// Field positions that the parser acts on.
	localparam logic [2:0] FIELD_HEADER = 3'd0;
	localparam logic [2:0] FIELD_LAT = 3'd2;
	localparam logic [2:0] FIELD_LON = 3'd4;
	localparam logic [3:0] LEN_SATURATED = 4'd15;

	typedef enum int {
		SENT_GOOD,
		SENT_BAD_LAT,
		SENT_BAD_LON,
		SENT_BAD_HEADER,
		SENT_EARLY
	} sent_kind_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	in_item_t byte_item = '0;
	logic byte_stall;
	logic cmd_valid;
	out_item_t cmd_item;
	logic cmd_stall = 1'b0;

	string header_text = "$GNGGA";
	string prefix_text = "AT+NMGS=24,0016";
	string hex_text = "0123456789abcdef";

	// Mirror of the parser state.
	logic [2:0] field_idx;
	logic [3:0] field_len;
	bit in_field;
	bit header_good;
	bit parse_done;
	logic [7:0] pos_store [POS_DEPTH];

	out_item_t cmd_expected[$];
	out_item_t cmd_want;
	logic [7:0] sentence_buf[$];

	int mismatch_count = 0;
	int bytes_used = 0;
	int cycle_count = 0;
	int hold_request = 0;
	int hold_left = 0;
	bit steady = 1'b0;

	always #4 clk = ~clk;

	gga_position_extract u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_item(byte_item),
		.byte_stall(byte_stall),
		.cmd_valid(cmd_valid),
		.cmd_item(cmd_item),
		.cmd_stall(cmd_stall)
	);

	// Prints one mismatch line and counts it.
	task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
		if (mismatch_count < PRINT_CAP) begin
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		end
		mismatch_count++;
	endtask

	// Parser state after reset: idle until a sentence start.
	task reset_parser();
		field_idx = FIELD_HEADER;
		field_len = '0;
		in_field = 1'b0;
		header_good = 1'b1;
		parse_done = 1'b1;
		for (int i = 0; i < POS_DEPTH; i++) begin
			pos_store[i] = '0;
		end
	endtask

	task push_result(input logic [7:0] b, input logic [1:0] st, input logic lst);
		out_item_t r;
		r.out_byte = b;
		r.status = st;
		r.last = lst;
		cmd_expected.push_back(r);
	endtask

	task push_hex(input logic [7:0] c);
		push_result(8'(hex_text[c[7:4]]), STAT_CMD, 1'b0);
		push_result(8'(hex_text[c[3:0]]), STAT_CMD, 1'b0);
	endtask

	// The full command: prefix, hex of latitude, comma and longitude, CR LF.
	task push_command();
		for (int i = 0; i < PREFIX_LEN; i++) begin
			push_result(8'(prefix_text[i]), STAT_CMD, 1'b0);
		end
		for (int i = 0; i < LAT_CHARS; i++) begin
			push_hex(pos_store[i]);
		end
		push_hex(CHAR_COMMA);
		for (int i = 0; i < LON_CHARS; i++) begin
			push_hex(pos_store[LAT_CHARS + i]);
		end
		push_result(CHAR_CR, STAT_CMD, 1'b0);
		push_result(CHAR_LF, STAT_CMD, 1'b1);
	endtask

	// Judges the field that just closed.
	task close_field();
		case (field_idx)
			FIELD_HEADER: begin
				if (!header_good || field_len < HEADER_LEN) begin
					parse_done = 1'b1;
				end
			end
			FIELD_LAT: begin
				if (field_len != LAT_CHARS) begin
					push_result(CHAR_NUL, STAT_LAT, 1'b1);
					parse_done = 1'b1;
				end
			end
			FIELD_LON: begin
				if (field_len != LON_CHARS) begin
					push_result(CHAR_NUL, STAT_LON, 1'b1);
				end else begin
					push_command();
				end
				parse_done = 1'b1;
			end
			default: begin
			end
		endcase
		field_idx = field_idx + 3'd1;
		in_field = 1'b0;
	endtask

	// Advances the mirrored parser by one accepted item.
	task predict_byte(input in_item_t it, output bit ignored);
		logic [7:0] c;
		c = it.data_byte;
		if (it.sentence_start) begin
			field_idx = FIELD_HEADER;
			field_len = '0;
			in_field = 1'b0;
			header_good = 1'b1;
			parse_done = 1'b0;
		end
		ignored = parse_done;
		if (parse_done) begin
		end else if (c == CHAR_COMMA || c == CHAR_NUL) begin
			if (in_field) begin
				close_field();
			end
			if (c == CHAR_NUL) begin
				parse_done = 1'b1;
			end
		end else begin
			if (!in_field) begin
				in_field = 1'b1;
				field_len = '0;
			end
			if (field_idx == FIELD_HEADER && field_len < HEADER_LEN &&
					c != 8'(header_text[field_len])) begin
				header_good = 1'b0;
			end
			if (field_idx == FIELD_LAT && field_len < LAT_CHARS) begin
				pos_store[field_len] = c;
			end
			if (field_idx == FIELD_LON && field_len < LON_CHARS) begin
				pos_store[LAT_CHARS + field_len] = c;
			end
			if (field_len != LEN_SATURATED) begin
				field_len = field_len + 4'd1;
			end
		end
	endtask

	// Offers one item, with random idle cycles first, and waits until it is taken.
	task send_byte(input logic [7:0] b, input logic st);
		in_item_t it;
		bit ignored;
		while (!steady && $urandom_range(99) < 38) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		it.data_byte = b;
		it.sentence_start = st;
		byte_item <= it;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall) begin
			@(posedge clk);
		end
		predict_byte(it, ignored);
		if (!ignored) begin
			bytes_used++;
		end
	endtask

	// Sender stops and waits until every predicted result has come out.
	task wait_for_results();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (cmd_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Sentence building.
	function automatic logic [7:0] field_char();
		logic [7:0] c;
		if ($urandom_range(1) == 1) begin
			c = 8'h30 + 8'($urandom_range(9));
		end else begin
			c = 8'($urandom_range(1, 255));
			if (c == CHAR_COMMA) begin
				c = 8'h2e;
			end
		end
		return c;
	endfunction

	task put_text(input string t);
		for (int i = 0; i < t.len(); i++) begin
			sentence_buf.push_back(8'(t[i]));
		end
	endtask

	task put_field(input int n);
		for (int i = 0; i < n; i++) begin
			sentence_buf.push_back(field_char());
		end
	endtask

	task put_commas(input int n);
		for (int i = 0; i < n; i++) begin
			sentence_buf.push_back(CHAR_COMMA);
		end
	endtask

	// Header, time, latitude, hemisphere and longitude, with no closing byte.
	task build_sentence(input int lat_len, input int lon_len);
		put_text("$GNGGA,1,");
		put_field(lat_len);
		put_text(",N,");
		put_field(lon_len);
	endtask

	// Sends the built sentence with the start flag on its first byte.
	task send_sentence();
		for (int i = 0; i < sentence_buf.size(); i++) begin
			send_byte(sentence_buf[i], i == 0);
		end
		sentence_buf.delete();
	endtask

	// Bytes before any sentence start are ignored; a start on a zero byte ends at once.
	task test_idle_bytes();
		send_byte(8'hff, 1'b0);
		send_byte(CHAR_COMMA, 1'b0);
		send_byte(CHAR_NUL, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(CHAR_NUL, 1'b1);
		send_byte(8'h24, 1'b0);
		send_byte(8'h7f, 1'b0);
		wait_for_results();
	endtask

	// Good sentence with empty fields and position bytes at the hex extremes.
	task test_edge_bytes();
		put_text("$GNGGA,,,1,,");
		sentence_buf.push_back(8'h01);
		sentence_buf.push_back(8'h0f);
		sentence_buf.push_back(8'h10);
		sentence_buf.push_back(8'h7f);
		sentence_buf.push_back(8'h80);
		sentence_buf.push_back(8'hff);
		put_text("39aZ");
		put_text(",N,,");
		sentence_buf.push_back(8'hfe);
		sentence_buf.push_back(8'h9a);
		sentence_buf.push_back(8'h5f);
		sentence_buf.push_back(8'h20);
		sentence_buf.push_back(8'h01);
		sentence_buf.push_back(8'hff);
		sentence_buf.push_back(8'h80);
		put_text("123.");
		put_text(",E,1");
		send_sentence();
		wait_for_results();
	endtask

	// A zero byte closes the longitude field like a comma and idles the parser.
	task test_zero_terminator();
		build_sentence(LAT_CHARS, LON_CHARS);
		sentence_buf.push_back(CHAR_NUL);
		put_text("5,");
		send_sentence();
		wait_for_results();
	endtask

	// Latitude one short, and far too long so that the length saturates.
	task test_latitude_length();
		build_sentence(LAT_CHARS - 1, LON_CHARS);
		put_text(",");
		send_sentence();
		build_sentence(18, LON_CHARS);
		put_text(",");
		send_sentence();
		wait_for_results();
	endtask

	// Longitude one long closed by a comma, one short closed by a zero byte.
	task test_longitude_length();
		build_sentence(LAT_CHARS, LON_CHARS + 1);
		put_text(",");
		send_sentence();
		build_sentence(LAT_CHARS, LON_CHARS - 1);
		sentence_buf.push_back(CHAR_NUL);
		send_sentence();
		wait_for_results();
	endtask

	// Wrong talker in the header, then a header one character short.
	task test_bad_header();
		put_text("$GPGGA,1,");
		put_field(LAT_CHARS);
		put_text(",N,");
		put_field(LON_CHARS);
		put_text(",");
		send_sentence();
		put_text("$GNGG,1,");
		put_field(LAT_CHARS);
		put_text(",N,");
		put_field(LON_CHARS);
		put_text(",");
		send_sentence();
		wait_for_results();
	endtask

	// A sentence cut inside the longitude, then a restart on a comma byte.
	task test_early_end();
		build_sentence(LAT_CHARS, 5);
		send_sentence();
		sentence_buf.push_back(CHAR_COMMA);
		build_sentence(LAT_CHARS, LON_CHARS);
		put_text(",");
		send_sentence();
		wait_for_results();
	endtask

	// Receiver holds off while error sentences and a good one keep coming.
	task test_output_backpressure();
		steady = 1'b1;
		hold_request = BACKPRESSURE_CYCLES;
		repeat (4) begin
			put_text("$GNGGA,1,");
			put_field(3);
			put_text(",");
			send_sentence();
		end
		build_sentence(LAT_CHARS, LON_CHARS);
		put_text(",");
		send_sentence();
		wait_for_results();
		steady = 1'b0;
	endtask

	// One random sentence, mostly well formed, with random content.
	task random_sentence();
		sent_kind_e kind;
		int pick;
		int lat_len;
		int lon_len;
		int cut;
		int p;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 55) begin
			kind = SENT_GOOD;
		end else if (pick < 70) begin
			kind = SENT_BAD_LAT;
		end else if (pick < 82) begin
			kind = SENT_BAD_LON;
		end else if (pick < 91) begin
			kind = SENT_BAD_HEADER;
		end else begin
			kind = SENT_EARLY;
		end
		lat_len = LAT_CHARS;
		lon_len = LON_CHARS;
		if (kind == SENT_BAD_LAT) begin
			do lat_len = $urandom_range(1, 18); while (lat_len == LAT_CHARS);
		end
		if (kind == SENT_BAD_LON) begin
			do lon_len = $urandom_range(1, 18); while (lon_len == LON_CHARS);
		end

		// Header field: short, corrupted in one character, or good with a tail.
		if (kind == SENT_BAD_HEADER && $urandom_range(1) == 1) begin
			put_text(header_text.substr(0, $urandom_range(0, 4)));
		end else begin
			put_text(header_text);
			if (kind == SENT_BAD_HEADER) begin
				p = $urandom_range(0, HEADER_LEN - 1);
				do c = field_char(); while (c == 8'(header_text[p]));
				sentence_buf[sentence_buf.size() - HEADER_LEN + p] = c;
			end
			put_field($urandom_range(0, 3));
		end

		put_commas($urandom_range(1, 3));
		put_field($urandom_range(1, 9));
		put_commas($urandom_range(1, 3));
		put_field(lat_len);
		put_commas($urandom_range(1, 2));
		put_field($urandom_range(1, 2));
		put_commas($urandom_range(1, 2));
		put_field(lon_len);

		// Close the longitude, or cut the sentence before it closes.
		if (kind == SENT_EARLY) begin
			cut = $urandom_range(1, sentence_buf.size() - 1);
			while (sentence_buf.size() > cut) begin
				sentence_buf.delete(sentence_buf.size() - 1);
			end
		end else if ($urandom_range(1) == 1) begin
			sentence_buf.push_back(CHAR_NUL);
		end else begin
			put_text(",");
			put_field(1);
			put_text(",1,08,");
		end
		send_sentence();
	endtask

	// Random sentences, with stray bytes between some and a stretch of no idling.
	task test_random_sentences();
		int first;
		int n;
		first = bytes_used;
		n = 0;
		while (bytes_used - first < RANDOM_BYTES) begin
			steady = (n == 1);
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(1, 4)) begin
					send_byte(8'($urandom_range(255)), 1'b0);
				end
			end
			random_sentence();
			n++;
		end
		steady = 1'b0;
	endtask

	// Receiver stall: long hold when requested, none while steady, otherwise random.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			cmd_stall <= 1'b1;
		end else if (steady) begin
			cmd_stall <= 1'b0;
		end else begin
			cmd_stall <= ($urandom_range(99) < 38);
		end
	end

	// Each accepted result against the oldest prediction, field by field.
	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) begin
			if (cmd_expected.size() == 0) begin
				report_mismatch("unexpected result byte", cmd_item.out_byte, 8'h00);
			end else begin
				cmd_want = cmd_expected.pop_front();
				if (cmd_item.out_byte !== cmd_want.out_byte) begin
					report_mismatch("out_byte", cmd_item.out_byte, cmd_want.out_byte);
				end
				if (cmd_item.status !== cmd_want.status) begin
					report_mismatch("status", 8'(cmd_item.status), 8'(cmd_want.status));
				end
				if (cmd_item.last !== cmd_want.last) begin
					report_mismatch("last", 8'(cmd_item.last), 8'(cmd_want.last));
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb_gga_position_extract: errors");
			$finish;
		end
	end

	// Reset, the tests in turn, then the verdict.
	initial begin
		reset_parser();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_bytes();
		test_edge_bytes();
		test_zero_terminator();
		test_latitude_length();
		test_longitude_length();
		test_bad_header();
		test_early_end();
		test_output_backpressure();
		test_random_sentences();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_gga_position_extract: clean");
		end else begin
			$display("tb_gga_position_extract: errors");
		end
		$finish;
	end

endmodule
